>>> design/imh_pkg.sv
// package for the indexed min-heap: sizes, word types, status codes, states
// no dependencies
`timescale 1ns / 1ps
package imh_pkg;
  localparam int Capacity  = 1024;
  localparam int KeyWidth  = 32;
  localparam int SlotW     = $clog2(Capacity);
  localparam int CountW    = $clog2(Capacity + 1);
  localparam int HandleW   = 10;
  localparam int HandleNum = 1 << HandleW;
  localparam int EntryW    = HandleW + KeyWidth;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [HandleW-1:0]  handle;
    logic [31:0]         key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [10:0]         count;
    logic                min_valid;
    logic [HandleW-1:0]  min_handle;
    logic [31:0]         min_key;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POS_RD, S_POS_WAIT, S_LAST_WAIT, S_UP_RD, S_UP_WAIT,
    S_DN_RD, S_DN_WAIT, S_DN_WAIT2, S_ROOT_RD, S_ROOT_WAIT, S_OUT, S_CLEAR
  } fsm_t;
endpackage

>>> design/indexed_min_heap_top.sv
// indexed binary min-heap: heap memory, position memory, sift sequencer
// depends on imh_pkg and imh_ram
`timescale 1ns / 1ps
// Usage: a word on the in_ channel inserts (opcode 0) a handle with its key or
// removes (opcode 1) a handle. Each word gives exactly one out_ word with the
// status, the entry count after the operation and the current minimum entry.
// Words are handled one at a time; in_stall is high while a word is at work
// or its result waits. A flagged word only reports the current minimum; an
// insert appends and rises level by level, and a remove looks up its slot and
// the last entry moved into it sinks or rises (at most 10 levels). A heap
// entry is read and written back through a single memory port.
// Reset starts a clearing pass over the position memory, whose top bit marks
// a present handle, with in_stall high. The heap memory needs no clearing.
// While out_stall is high the result holds in out_word and no new input is
// taken.
module indexed_min_heap_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  imh_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output imh_pkg::out_word_t out_word
);
  import imh_pkg::*;

  fsm_t state_r, state_nxt;
  logic [HandleW-1:0] clr_r, clr_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              op_r, op_nxt;
  logic [HandleW-1:0] hnd_r, hnd_nxt;
  logic [KeyWidth-1:0] key_r, key_nxt;
  logic [SlotW-1:0]  slot_r, slot_nxt;
  logic [SlotW-1:0]  other_r, other_nxt;  // parent or child slot
  logic [EntryW-1:0] left_r, left_nxt;    // held left child
  logic              moved_r, moved_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r;
  out_word_t         out_r;

  logic              h_we, p_we, load_out;
  logic [SlotW-1:0]  h_addr;
  logic [EntryW-1:0] h_wdata, h_rdata;
  logic [HandleW-1:0] p_addr;
  logic [SlotW:0]    p_wdata, p_rdata;  // present bit on top of the slot

  imh_ram #(.Width(EntryW), .Depth(Capacity)) u_heap (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
  imh_ram #(.Width(SlotW + 1), .Depth(HandleNum)) u_pos (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));

  logic [KeyWidth-1:0] rd_key;
  logic [HandleW-1:0]  rd_hnd;
  logic [SlotW:0]      lchild;   // wide enough to compare against count
  assign rd_hnd = h_rdata[EntryW-1 -: HandleW];
  assign rd_key = h_rdata[KeyWidth-1:0];
  assign lchild = {slot_r, 1'b1};

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r;
    count_nxt = count_r; op_nxt = op_r; hnd_nxt = hnd_r; key_nxt = key_r;
    slot_nxt = slot_r; other_nxt = other_r; left_nxt = left_r;
    moved_nxt = moved_r; status_nxt = status_r;
    h_we = 1'b0; h_addr = slot_r; h_wdata = {hnd_r, key_r};
    p_we = 1'b0; p_addr = hnd_r; p_wdata = {1'b1, slot_r};
    load_out = 1'b0;
    case (state_r)
      S_CLEAR: begin
        p_we = 1'b1; p_addr = clr_r; p_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HandleW'(HandleNum - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt = in_word.opcode; hnd_nxt = in_word.handle;
          key_nxt = in_word.key[KeyWidth-1:0];
          status_nxt = ST_OK;
          state_nxt = S_POS_RD;
        end
      end
      S_POS_RD: begin
        p_addr = hnd_r;
        state_nxt = S_POS_WAIT;
      end
      S_POS_WAIT: begin
        if (op_r == OP_INSERT) begin
          if (p_rdata[SlotW]) begin
            status_nxt = ST_PRESENT; state_nxt = S_ROOT_RD;
          end else if (count_r == CountW'(Capacity)) begin
            status_nxt = ST_FULL; state_nxt = S_ROOT_RD;
          end else begin
            // append, then walk toward the root
            slot_nxt = count_r[SlotW-1:0];
            count_nxt = count_r + 1'b1;
            state_nxt = S_UP_RD;
          end
        end else if (!p_rdata[SlotW]) begin
          status_nxt = ST_ABSENT; state_nxt = S_ROOT_RD;
        end else begin
          p_we = 1'b1; p_addr = hnd_r; p_wdata = '0;
          count_nxt = count_r - 1'b1;
          slot_nxt = p_rdata[SlotW-1:0];
          if ({1'b0, p_rdata[SlotW-1:0]} < count_nxt) begin
            h_addr = count_nxt[SlotW-1:0];
            state_nxt = S_LAST_WAIT;
          end else begin
            state_nxt = S_ROOT_RD;
          end
        end
      end
      S_LAST_WAIT: begin
        // last entry now travels into the freed slot
        hnd_nxt = rd_hnd; key_nxt = rd_key;
        moved_nxt = 1'b0;
        state_nxt = S_DN_RD;
      end
      S_UP_RD: begin
        if (slot_r == '0) begin
          h_we = 1'b1; p_we = 1'b1; state_nxt = S_ROOT_RD;
        end else begin
          other_nxt = (slot_r - 1'b1) >> 1;
          h_addr = (slot_r - 1'b1) >> 1;
          state_nxt = S_UP_WAIT;
        end
      end
      S_UP_WAIT: begin
        if (key_r < rd_key) begin
          // parent moves down into our slot
          h_we = 1'b1; h_addr = slot_r; h_wdata = h_rdata;
          p_we = 1'b1; p_addr = rd_hnd; p_wdata = {1'b1, slot_r};
          slot_nxt = other_r;
          state_nxt = S_UP_RD;
        end else begin
          h_we = 1'b1; p_we = 1'b1; state_nxt = S_ROOT_RD;
        end
      end
      S_DN_RD: begin
        if (lchild >= count_r) begin
          if (moved_r) begin
            h_we = 1'b1; p_we = 1'b1; state_nxt = S_ROOT_RD;
          end else begin
            state_nxt = S_UP_RD;
          end
        end else begin
          h_addr = lchild[SlotW-1:0];
          other_nxt = lchild[SlotW-1:0];
          state_nxt = S_DN_WAIT;
        end
      end
      S_DN_WAIT: begin
        left_nxt = h_rdata;
        if ({1'b0, other_r} + 1'b1 < count_r) begin
          h_addr = other_r + 1'b1;
          state_nxt = S_DN_WAIT2;
        end else if (h_rdata[KeyWidth-1:0] < key_r) begin
          h_we = 1'b1; h_wdata = h_rdata;
          p_we = 1'b1; p_addr = rd_hnd;
          slot_nxt = other_r; moved_nxt = 1'b1;
          state_nxt = S_DN_RD;
        end else if (moved_r) begin
          h_we = 1'b1; p_we = 1'b1; state_nxt = S_ROOT_RD;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_DN_WAIT2: begin
        if (rd_key < left_r[KeyWidth-1:0]) begin
          if (rd_key < key_r) begin
            h_we = 1'b1; h_wdata = h_rdata;
            p_we = 1'b1; p_addr = rd_hnd;
            slot_nxt = other_r + 1'b1; moved_nxt = 1'b1;
            state_nxt = S_DN_RD;
          end else if (moved_r) begin
            h_we = 1'b1; p_we = 1'b1; state_nxt = S_ROOT_RD;
          end else begin
            state_nxt = S_UP_RD;
          end
        end else if (left_r[KeyWidth-1:0] < key_r) begin
          h_we = 1'b1; h_wdata = left_r;
          p_we = 1'b1; p_addr = left_r[EntryW-1 -: HandleW];
          slot_nxt = other_r; moved_nxt = 1'b1;
          state_nxt = S_DN_RD;
        end else if (moved_r) begin
          h_we = 1'b1; p_we = 1'b1; state_nxt = S_ROOT_RD;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_ROOT_RD: begin
        h_addr = '0; state_nxt = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        load_out = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      count_r <= count_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; hnd_r <= hnd_nxt; key_r <= key_nxt;
    slot_r <= slot_nxt; other_r <= other_nxt; left_r <= left_nxt;
    moved_r <= moved_nxt; status_r <= status_nxt;
    if (load_out) begin
      out_r.status    <= status_r;
      out_r.count     <= 11'(count_r);
      out_r.min_valid <= (count_r != '0);
      out_r.min_handle <= (count_r != '0) ? rd_hnd : '0;
      out_r.min_key   <= (count_r != '0) ? 32'(rd_key) : '0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(Capacity)) else $error("count beyond capacity");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r) else $error("result overwritten");
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.min_valid) |-> (out_r.count == '0))
    else $error("min flag disagrees with count");
endmodule

>>> design/imh_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps
module imh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> test/indexed_min_heap_top_tb.sv
// testbench for indexed_min_heap_top: random and directed insert/remove words
// checked against an in-bench heap predictor; depends on imh_pkg and the design
`timescale 1ns / 1ps
module indexed_min_heap_top_tb;
  import imh_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  indexed_min_heap_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic [HandleW-1:0] hp_handle [Capacity];
  logic [31:0]        hp_key [Capacity];
  int                 pos_of [HandleNum];
  bit                 present [HandleNum];
  int                 n_entries;

  in_word_t  pending_words [$];
  out_word_t expected_results [$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;
  bit        all_sent;
  longint    cycle_count = 0;

  function automatic void swap_slots(int a, int b);
    logic [HandleW-1:0] h;
    logic [31:0]        k;
    h = hp_handle[a]; k = hp_key[a];
    hp_handle[a] = hp_handle[b]; hp_key[a] = hp_key[b];
    hp_handle[b] = h; hp_key[b] = k;
    pos_of[hp_handle[a]] = a;
    pos_of[hp_handle[b]] = b;
  endfunction

  function automatic void sift_up(int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (hp_key[s] < hp_key[p]) begin
        swap_slots(s, p);
        s = p;
      end else break;
    end
  endfunction

  function automatic bit sift_down(int s);
    int l;
    int pick;
    bit moved;
    moved = 0;
    forever begin
      l = 2 * s + 1;
      if (l >= n_entries) break;
      pick = l;
      if (l + 1 < n_entries && hp_key[l + 1] < hp_key[l]) pick = l + 1;
      if (hp_key[pick] < hp_key[s]) begin
        swap_slots(s, pick);
        s = pick;
        moved = 1;
      end else break;
    end
    return moved;
  endfunction

  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t r;
    int s;
    status_t st;
    st = ST_OK;
    if (w.opcode == OP_INSERT) begin
      if (present[w.handle]) st = ST_PRESENT;
      else if (n_entries >= Capacity) st = ST_FULL;
      else begin
        hp_handle[n_entries] = w.handle;
        hp_key[n_entries] = w.key;
        pos_of[w.handle] = n_entries;
        present[w.handle] = 1;
        n_entries++;
        sift_up(n_entries - 1);
      end
    end else begin
      if (!present[w.handle]) st = ST_ABSENT;
      else begin
        s = pos_of[w.handle];
        present[w.handle] = 0;
        n_entries--;
        if (s < n_entries) begin
          hp_handle[s] = hp_handle[n_entries];
          hp_key[s] = hp_key[n_entries];
          pos_of[hp_handle[s]] = s;
          if (!sift_down(s)) sift_up(s);
        end
      end
    end
    r.status = st;
    r.count = n_entries[10:0];
    r.min_valid = (n_entries > 0);
    r.min_handle = (n_entries > 0) ? hp_handle[0] : '0;
    r.min_key = (n_entries > 0) ? hp_key[0] : '0;
    return r;
  endfunction

  function automatic in_word_t make_word(logic op, int h, logic [31:0] k);
    in_word_t w;
    w.opcode = op;
    w.handle = h[HandleW-1:0];
    w.key = k;
    return w;
  endfunction

  // key with a bias toward small ranges and ties
  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return $urandom();
      2: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor: predict at input accept, check at output accept
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(heap_apply(in_word));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_word);
        end else begin
          exp_w = expected_results.pop_front();
          if (out_word.status !== exp_w.status || out_word.count !== exp_w.count ||
              out_word.min_valid !== exp_w.min_valid ||
              out_word.min_handle !== exp_w.min_handle ||
              out_word.min_key !== exp_w.min_key) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected st=%0d cnt=%0d v=%0d h=%0d k=%h, got st=%0d cnt=%0d v=%0d h=%0d k=%h",
                       exp_w.status, exp_w.count, exp_w.min_valid, exp_w.min_handle,
                       exp_w.min_key, out_word.status, out_word.count,
                       out_word.min_valid, out_word.min_handle, out_word.min_key);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int live [$];
    int h;
    int idx;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    mismatches = 0;
    n_entries = 0;
    hold_cycles = 0;
    send_idle_pct = 16;
    recv_idle_pct = 74;
    for (int i = 0; i < HandleNum; i++) begin
      present[i] = 0;
      pos_of[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty remove, extremes, duplicate, ties, last-slot remove
    pending_words.push_back(make_word(OP_REMOVE, 0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_INSERT, 1023, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_INSERT, 0, 32'h0));
    pending_words.push_back(make_word(OP_INSERT, 0, 32'h5));
    pending_words.push_back(make_word(OP_INSERT, 341, 32'h0));
    pending_words.push_back(make_word(OP_INSERT, 682, 32'h8000_0000));
    pending_words.push_back(make_word(OP_INSERT, 85, 32'h7FFF_FFFF));
    pending_words.push_back(make_word(OP_INSERT, 170, 32'h0001_0000));
    pending_words.push_back(make_word(OP_REMOVE, 170, 32'h0));
    pending_words.push_back(make_word(OP_REMOVE, 0, 32'hAAAA_5555));
    pending_words.push_back(make_word(OP_REMOVE, 0, 32'h0));
    pending_words.push_back(make_word(OP_REMOVE, 1023, 32'h0));
    pending_words.push_back(make_word(OP_INSERT, 512, 32'h0000_FFFF));
    pending_words.push_back(make_word(OP_INSERT, 1023, 32'h1));
    pending_words.push_back(make_word(OP_REMOVE, 341, 32'h0));
    pending_words.push_back(make_word(OP_REMOVE, 682, 32'h0));
    pending_words.push_back(make_word(OP_REMOVE, 85, 32'h0));
    pending_words.push_back(make_word(OP_REMOVE, 512, 32'h0));
    pending_words.push_back(make_word(OP_REMOVE, 1023, 32'h0));
    wait_drained();

    // random phases; tracking the live handles lets most removes hit
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 16 : 0;
      if (phase == 2) hold_cycles = 600;
      for (int i = 0; i < 150; i++) begin
        idx = $urandom_range(0, 99);
        if (live.size() > 0 && idx < 40) begin
          idx = $urandom_range(0, live.size() - 1);
          h = live[idx];
          live.delete(idx);
          pending_words.push_back(make_word(OP_REMOVE, h, $urandom()));
        end else if (idx < 85) begin
          h = $urandom_range(0, HandleNum - 1);
          pending_words.push_back(make_word(OP_INSERT, h, rand_key()));
          live.push_back(h);
        end else if (idx < 93 && live.size() > 0) begin
          h = live[$urandom_range(0, live.size() - 1)];
          pending_words.push_back(make_word(OP_INSERT, h, rand_key()));
        end else begin
          pending_words.push_back(make_word($urandom_range(0, 1),
                                            $urandom_range(0, HandleNum - 1), $urandom()));
        end
        // keep the live list free of repeats from random inserts
        for (int j = 0; j + 1 < live.size(); j++)
          if (live[j] == live[live.size() - 1]) begin
            live.delete(live.size() - 1);
            break;
          end
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
